FILE: rtl/yuvov_pkg.sv
// Package for the centered YUV 4:2:0 image overlay.
// Holds payload structs, field widths, register indexes and codes.
// No dependencies.
package yuvov_pkg;

   localparam int PIX_W   = 8;
   localparam int VDIM_W  = 13;
   localparam int IDIM_W  = 9;
   localparam int IADDR_W = 17;
   localparam int PLANE_W = 2;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_VIDEO = 1'b1;

   localparam logic [PLANE_W-1:0] PLANE_Y = 2'd0;
   localparam logic [PLANE_W-1:0] PLANE_U = 2'd1;
   localparam logic [PLANE_W-1:0] PLANE_V = 2'd2;

   localparam logic [1:0] REG_VIDEO_WIDTH  = 2'd0;
   localparam logic [1:0] REG_VIDEO_HEIGHT = 2'd1;
   localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd2;
   localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd3;

   localparam logic [VDIM_W-1:0] VIDEO_WIDTH_RST  = 13'd1920;
   localparam logic [VDIM_W-1:0] VIDEO_HEIGHT_RST = 13'd1080;
   localparam logic [IDIM_W-1:0] IMAGE_WIDTH_RST  = 9'd256;
   localparam logic [IDIM_W-1:0] IMAGE_HEIGHT_RST = 9'd256;

   localparam int MIN_VIDEO_DIM = 2;

   typedef struct packed {
      logic               kind;
      logic [PIX_W-1:0]   pixel;
      logic [IADDR_W-1:0] image_address;
   } req_type;

   typedef struct packed {
      logic [PIX_W-1:0]   pixel_out;
      logic [PLANE_W-1:0] plane;
      logic               replaced;
      logic               frame_end;
   } rsp_type;

endpackage

FILE: rtl/yuvov_ram.sv
// Generic single-clock RAM: one write port, one read port, registered read.
// No dependencies.
module yuvov_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_ff;

endmodule

FILE: rtl/yuv420_centered_image_overlay.sv
// Top level of the centered YUV 4:2:0 image overlay.
// Depends on yuvov_pkg (types, codes) and yuvov_ram (image store).
//
//   channel | ports                       | moves per transfer
//   --------+-----------------------------+------------------------------------
//   req     | req_valid/req_stall/req_data | one load byte or one video byte
//   rsp     | rsp_valid/rsp_stall/rsp_data | one video byte after overlay
//   csr     | csr_p* (APB style)          | one 32-bit register write or read
//
// One item enters per cycle while req_stall is low; a video byte passes stage 1,
// stage 2, stage 3 and the output register before it shows on rsp_valid.
// The rate is set by the image store: one access per cycle unless stage 3 stalls, on a
// single write and read port, loads writing and video bytes reading in the same stage.
// Each stage advances when the one after it is empty or advancing, so bubbles close.
// Reset clears the pipe and frame counters and presets the registers; the store stays.
module yuv420_centered_image_overlay #(
   parameter int MAX_IMAGE_WIDTH  = 256,
   parameter int MAX_IMAGE_HEIGHT = 256,
   parameter int MAX_VIDEO_DIM    = 4096
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  yuvov_pkg::req_type                   req_data,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output yuvov_pkg::rsp_type                   rsp_data,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [yuvov_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [yuvov_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [yuvov_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                 csr_pready
);

   import yuvov_pkg::*;

   localparam int STORE_DEPTH = (MAX_IMAGE_WIDTH * MAX_IMAGE_HEIGHT * 3) / 2;
   localparam int STORE_AW    = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int DW          = $clog2(MAX_VIDEO_DIM + 1);
   // dimension math width: holds video and image sizes plus one carry bit
   localparam int XW          = ((DW > IDIM_W + 1) ? DW : IDIM_W + 1) + 1;
   localparam int CW          = (MAX_VIDEO_DIM > 2) ? $clog2(MAX_VIDEO_DIM) : 1;
   localparam int MULT_W      = 2 * IDIM_W;
   localparam int BASE_W      = MULT_W + 1;
   localparam int SUM_W       = MULT_W + 2;

   // ---------------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------------
   logic [VDIM_W-1:0] vw_ff, vh_ff;
   logic [IDIM_W-1:0] iw_ff, ih_ff;
   logic              csr_wr;
   logic [1:0]        csr_index;

   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[3:2];
   assign csr_pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         vw_ff <= VIDEO_WIDTH_RST;
         vh_ff <= VIDEO_HEIGHT_RST;
         iw_ff <= IMAGE_WIDTH_RST;
         ih_ff <= IMAGE_HEIGHT_RST;
      end else if (csr_wr) begin
         unique case (csr_index)
            REG_VIDEO_WIDTH:  vw_ff <= csr_pwdata[VDIM_W-1:0];
            REG_VIDEO_HEIGHT: vh_ff <= csr_pwdata[VDIM_W-1:0];
            REG_IMAGE_WIDTH:  iw_ff <= csr_pwdata[IDIM_W-1:0];
            REG_IMAGE_HEIGHT: ih_ff <= csr_pwdata[IDIM_W-1:0];
            default:          ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_index)
         REG_VIDEO_WIDTH:  csr_prdata = CSR_DATA_W'(vw_ff);
         REG_VIDEO_HEIGHT: csr_prdata = CSR_DATA_W'(vh_ff);
         REG_IMAGE_WIDTH:  csr_prdata = CSR_DATA_W'(iw_ff);
         REG_IMAGE_HEIGHT: csr_prdata = CSR_DATA_W'(ih_ff);
         default:          csr_prdata = '0;
      endcase
   end

   // Clamp a video dimension to the supported range.
   function automatic logic [XW-1:0] sat_dim(input logic [VDIM_W-1:0] v);
      logic [XW-1:0] r;
      if (v < VDIM_W'(MIN_VIDEO_DIM)) begin
         r = XW'(MIN_VIDEO_DIM);
      end else if (32'(v) > MAX_VIDEO_DIM) begin
         r = XW'(MAX_VIDEO_DIM);
      end else begin
         r = XW'(v);
      end
      return r;
   endfunction

   logic [XW-1:0] vw_sat, vh_sat;
   assign vw_sat = sat_dim(vw_ff);
   assign vh_sat = sat_dim(vh_ff);

   // ---------------------------------------------------------------------------
   // Window geometry, registered anew every cycle from the registers. The user must
   // change the registers only while the pipe is empty; the block does not enforce it.
   // ---------------------------------------------------------------------------
   logic              ov_en;
   logic [XW-1:0]     woff_raw, hoff_raw;
   logic              ov_en_ff;
   logic [XW-1:0]     woff_ff, hoff_ff;
   logic [MULT_W-1:0] prod_a_ff, prod_b_ff;
   logic [BASE_W-1:0] base_u_ff, base_v_ff;

   assign ov_en = (XW'(iw_ff) <= vw_sat) && (XW'(ih_ff) <= vh_sat) &&
                  (32'(iw_ff) <= MAX_IMAGE_WIDTH) && (32'(ih_ff) <= MAX_IMAGE_HEIGHT);
   assign woff_raw = (vw_sat - XW'(iw_ff)) >> 1;
   assign hoff_raw = (vh_sat - XW'(ih_ff)) >> 1;

   always_ff @(posedge clock) begin
      ov_en_ff  <= ov_en;
      // round each offset up to even
      woff_ff   <= woff_raw + XW'(woff_raw[0]);
      hoff_ff   <= hoff_raw + XW'(hoff_raw[0]);
      prod_a_ff <= iw_ff * ih_ff;
      prod_b_ff <= MULT_W'(iw_ff >> 1) * MULT_W'(ih_ff >> 1);
      base_u_ff <= BASE_W'(prod_a_ff);
      base_v_ff <= BASE_W'(prod_a_ff) + BASE_W'(prod_b_ff);
   end

   // ---------------------------------------------------------------------------
   // Stage handshakes: a stage advances when the next one is empty or advancing.
   // ---------------------------------------------------------------------------
   logic s1_v_ff, s2_v_ff, s3_v_ff, out_v_ff;
   logic s1_v_in, s2_v_in, s3_v_in, out_v_in;
   logic out_en, s3_en, s2_en, s1_en;
   logic accept;

   assign out_en    = !out_v_ff || !rsp_stall;
   assign s3_en     = !s3_v_ff || out_en;
   assign s2_en     = !s2_v_ff || s3_en;
   assign s1_en     = !s1_v_ff || s2_en;
   assign req_stall = !s1_en;
   assign accept    = req_valid && s1_en;

   // ---------------------------------------------------------------------------
   // Frame position counters, advanced at each video byte transfer
   // ---------------------------------------------------------------------------
   logic [PLANE_W-1:0] plane_ff, plane_in;
   logic [CW-1:0]      col_ff, col_in, row_ff, row_in;
   logic [XW-1:0]      pw, ph;
   logic               col_wrap, row_wrap, last;
   logic               video_acc;

   assign video_acc = accept && (req_data.kind == KIND_VIDEO);
   assign pw        = (plane_ff == PLANE_Y) ? vw_sat : (vw_sat >> 1);
   assign ph        = (plane_ff == PLANE_Y) ? vh_sat : (vh_sat >> 1);
   assign col_wrap  = (XW'(col_ff) + XW'(1)) >= pw;
   assign row_wrap  = (XW'(row_ff) + XW'(1)) >= ph;
   assign last      = (plane_ff == PLANE_V) && col_wrap && row_wrap;

   always_comb begin
      plane_in = plane_ff;
      row_in   = row_ff;
      col_in   = col_ff + CW'(1);
      if (col_wrap) begin
         col_in = '0;
         if (row_wrap) begin
            row_in   = '0;
            plane_in = (plane_ff >= PLANE_V) ? PLANE_Y : plane_ff + PLANE_W'(1);
         end else begin
            row_in = row_ff + CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= PLANE_Y;
         col_ff   <= '0;
         row_ff   <= '0;
      end else if (video_acc) begin
         plane_ff <= plane_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: item with its frame position
   // ---------------------------------------------------------------------------
   req_type            s1_req_ff;
   logic [PLANE_W-1:0] s1_plane_ff;
   logic [CW-1:0]      s1_col_ff, s1_row_ff;
   logic               s1_last_ff;

   assign s1_v_in = s1_en ? accept : s1_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_v_ff <= 1'b0;
      end else begin
         s1_v_ff <= s1_v_in;
      end
      if (accept) begin
         s1_req_ff   <= req_data;
         s1_plane_ff <= plane_ff;
         s1_col_ff   <= col_ff;
         s1_row_ff   <= row_ff;
         s1_last_ff  <= last;
      end
   end

   // window test: luma window at the offsets, chroma window at half of them
   logic [XW-1:0]     wx, wy, colx, rowx;
   logic [IDIM_W-1:0] ww, wh;
   logic              in_win;

   assign wx     = (s1_plane_ff == PLANE_Y) ? woff_ff : (woff_ff >> 1);
   assign wy     = (s1_plane_ff == PLANE_Y) ? hoff_ff : (hoff_ff >> 1);
   assign ww     = (s1_plane_ff == PLANE_Y) ? iw_ff : (iw_ff >> 1);
   assign wh     = (s1_plane_ff == PLANE_Y) ? ih_ff : (ih_ff >> 1);
   assign colx   = XW'(s1_col_ff);
   assign rowx   = XW'(s1_row_ff);
   assign in_win = ov_en_ff && (colx >= wx) && (colx < wx + XW'(ww)) &&
                   (rowx >= wy) && (rowx < wy + XW'(wh));

   // ---------------------------------------------------------------------------
   // Stage 2: store access. Loads write, video bytes in the window use the read data.
   // ---------------------------------------------------------------------------
   logic               s2_kind_ff;
   logic [PIX_W-1:0]   s2_pixel_ff;
   logic [IADDR_W-1:0] s2_addr_ff;
   logic [PLANE_W-1:0] s2_plane_ff;
   logic               s2_last_ff, s2_rep_ff;
   logic [IDIM_W-1:0]  s2_dr_ff, s2_dc_ff, s2_ww_ff;

   assign s2_v_in = s2_en ? s1_v_ff : s2_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_v_ff <= 1'b0;
      end else begin
         s2_v_ff <= s2_v_in;
      end
      if (s2_en) begin
         s2_kind_ff  <= s1_req_ff.kind;
         s2_pixel_ff <= s1_req_ff.pixel;
         s2_addr_ff  <= s1_req_ff.image_address;
         s2_plane_ff <= s1_plane_ff;
         s2_last_ff  <= s1_last_ff;
         s2_rep_ff   <= in_win;
         s2_dr_ff    <= IDIM_W'(rowx - wy);
         s2_dc_ff    <= IDIM_W'(colx - wx);
         s2_ww_ff    <= ww;
      end
   end

   logic [BASE_W-1:0]   base_sel;
   logic [MULT_W-1:0]   row_ofs;
   logic [SUM_W-1:0]    rd_full;
   logic                ram_we, ram_re;
   logic [STORE_AW-1:0] ram_waddr, ram_raddr;
   logic [PIX_W-1:0]    ram_rdata;

   always_comb begin
      unique case (s2_plane_ff)
         PLANE_U: base_sel = base_u_ff;
         PLANE_V: base_sel = base_v_ff;
         default: base_sel = '0;
      endcase
   end

   assign row_ofs   = s2_dr_ff * s2_ww_ff;
   assign rd_full   = SUM_W'(base_sel) + SUM_W'(row_ofs) + SUM_W'(s2_dc_ff);
   assign ram_raddr = STORE_AW'(rd_full);
   assign ram_waddr = STORE_AW'(s2_addr_ff);
   // drop loads beyond the store
   assign ram_we    = s2_v_ff && (s2_kind_ff == KIND_LOAD) && s3_en &&
                      (32'(s2_addr_ff) < STORE_DEPTH);
   // hold read data while stage 3 is stalled
   assign ram_re    = s3_en;

   yuvov_ram #(
      .WIDTH (PIX_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (s2_pixel_ff),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------------------
   // Stage 3: store data arrives; only video bytes continue
   // ---------------------------------------------------------------------------
   logic [PIX_W-1:0]   s3_pixel_ff;
   logic [PLANE_W-1:0] s3_plane_ff;
   logic               s3_rep_ff, s3_last_ff;
   rsp_type            rsp_in;

   assign s3_v_in = s3_en ? (s2_v_ff && (s2_kind_ff == KIND_VIDEO)) : s3_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_v_ff <= 1'b0;
      end else begin
         s3_v_ff <= s3_v_in;
      end
      if (s3_en) begin
         s3_pixel_ff <= s2_pixel_ff;
         s3_plane_ff <= s2_plane_ff;
         s3_rep_ff   <= s2_rep_ff;
         s3_last_ff  <= s2_last_ff;
      end
   end

   always_comb begin
      rsp_in.pixel_out = s3_rep_ff ? ram_rdata : s3_pixel_ff;
      rsp_in.plane     = s3_plane_ff;
      rsp_in.replaced  = s3_rep_ff;
      rsp_in.frame_end = s3_last_ff;
   end

   // ---------------------------------------------------------------------------
   // Output register
   // ---------------------------------------------------------------------------
   rsp_type rsp_ff;

   assign out_v_in = out_en ? s3_v_ff : out_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff <= 1'b0;
      end else begin
         out_v_ff <= out_v_in;
      end
      if (out_en) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = rsp_ff;

   // ---------------------------------------------------------------------------
   // Assertions
   // ---------------------------------------------------------------------------
   a_plane_range : assert property (@(posedge clock) disable iff (reset)
      plane_ff <= PLANE_V)
      else $error("plane counter out of range");

   a_frame_end_on_v : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.frame_end |-> rsp_data.plane == PLANE_V)
      else $error("frame end outside the V plane");

   a_out_from_s3 : assert property (@(posedge clock) disable iff (reset)
      $rose(out_v_ff) |-> $past(s3_v_ff))
      else $error("result appeared without a stage 3 item");

   a_accept_fills_s1 : assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> s1_v_ff)
      else $error("transfer did not reach stage 1");

endmodule
